// ----- design/scq_pkg.sv -----
// ----------------------------------------------------------------------------
// scq_pkg
// shared types and constants of the scan code event queue
// ----------------------------------------------------------------------------
package scq_pkg;

  // default ring size, one slot always kept empty
  localparam int unsigned QUEUE_DEPTH_DEF = 32;

  localparam logic [7:0]  EXT_PREFIX = 8'hE0;
  localparam int unsigned DROP_W     = 16;
  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_op_t;

  // one command handed from the front to the back
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] scan;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RD_WAIT
  } bk_state_t;

endpackage

// ----- design/scq_ram.sv -----
// ----------------------------------------------------------------------------
// scq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module scq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- design/scq_front.sv -----
// ----------------------------------------------------------------------------
// scq_front
// accepts input beats, filters aux and prefix bytes, queues commands
// ----------------------------------------------------------------------------
module scq_front
  import scq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_scan_byte,
  input  logic       in_from_aux,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  cmd_t       slot_r [2];
  cmd_t       new_cmd;
  logic       keep;
  logic       push;

  assign in_stall = (count_r == 2'd2);

  // reads always go through, bytes only when not aux and not the prefix
  assign keep = in_req_type || (!in_from_aux && (in_scan_byte != EXT_PREFIX));
  assign push = in_valid && !in_stall && keep;

  always_comb begin
    new_cmd.op   = in_req_type ? CMD_READ : CMD_PUSH;
    new_cmd.scan = in_scan_byte;
  end

  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    unique case ({push, cmd_take})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (cmd_take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- design/scq_back.sv -----
// ----------------------------------------------------------------------------
// scq_back
// runs queued commands against the event ring and drives the result beat
// ----------------------------------------------------------------------------
module scq_back
  import scq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_event_valid,
  output logic [6:0]        out_key_code,
  output logic              out_key_pressed,
  output logic [DROP_W-1:0] out_drop_total
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(QUEUE_DEPTH - 1);

  bk_state_t         state_r, state_nxt;
  logic [AW-1:0]     wp_r, rp_r, wp_inc, rp_inc;
  logic [DROP_W-1:0] drop_r;
  logic              out_valid_r;
  logic              out_free;
  logic              full, empty;
  logic              ram_we, ram_re;
  logic              load_empty, load_evt;
  logic [7:0]        rd_data;

  assign wp_inc   = (wp_r == LAST_POS) ? '0 : wp_r + 1'b1;
  assign rp_inc   = (rp_r == LAST_POS) ? '0 : rp_r + 1'b1;
  assign full     = (wp_inc == rp_r);
  assign empty    = (wp_r == rp_r);
  assign out_free = !out_valid_r || !out_stall;

  // command issue and result loads
  always_comb begin
    cmd_take   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load_empty = 1'b0;
    load_evt   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == CMD_PUSH) begin
            cmd_take = 1'b1;
            ram_we   = !full;
          end else if (out_free) begin
            cmd_take   = 1'b1;
            load_empty = empty;
            ram_re     = !empty;
          end
        end
      end
      BK_RD_WAIT: begin
        load_evt = out_free;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      BK_IDLE:    state_nxt = ram_re ? BK_RD_WAIT : BK_IDLE;
      BK_RD_WAIT: state_nxt = load_evt ? BK_IDLE : BK_RD_WAIT;
    endcase
  end

  scq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (cmd.scan),
    .rd_en   (ram_re),
    .rd_addr (rp_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        wp_r <= wp_inc;
      end
      if (ram_re) begin
        rp_r <= rp_inc;
      end
      if (cmd_take && (cmd.op == CMD_PUSH) && full && (drop_r != DROP_MAX)) begin
        drop_r <= drop_r + 1'b1;
      end
      if (load_empty || load_evt) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      out_event_valid <= 1'b0;
      out_key_code    <= 7'd0;
      out_key_pressed <= 1'b0;
      out_drop_total  <= drop_r;
    end else if (load_evt) begin
      out_event_valid <= 1'b1;
      out_key_code    <= rd_data[6:0];
      out_key_pressed <= !rd_data[7];
      out_drop_total  <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/scan_code_event_queue.sv -----
// ----------------------------------------------------------------------------
// scan_code_event_queue
// keyboard scan code filter and event ring with a read port
// ----------------------------------------------------------------------------
// usage
//   input beat: in_req_type 0 carries a controller byte (in_scan_byte,
//   in_from_aux), in_req_type 1 asks for the oldest queued key event
//   aux bytes and the extended prefix are dropped without a trace, any other
//   byte is queued; a byte never gives an output beat, a read always does
//   output beat: out_event_valid low means the ring was empty, out_drop_total
//   counts events lost to a full ring and saturates at its top value
//   path: an empty read passes the command queue slot then the output register;
//   a read that finds an event also passes the registered ram read port
//   throughput: bytes one per cycle while in_stall is low; a read that finds an
//   event holds the back until its output load, otherwise one per cycle
//   the ring holds QUEUE_DEPTH - 1 events
//   reset clears pointers, the command count, the drop counter and out_valid; the ring
//   storage itself is not cleared, only written slots are ever read
//   while out_stall is high the output beat holds; the two-entry command
//   queue keeps taking input beats until it fills, then in_stall rises
// ----------------------------------------------------------------------------
module scan_code_event_queue
  import scq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [7:0]        in_scan_byte,
  input  logic              in_from_aux,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_event_valid,
  output logic [6:0]        out_key_code,
  output logic              out_key_pressed,
  output logic [DROP_W-1:0] out_drop_total
);

  // command queue between filter and ring control
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // front: filter input beats into push and read commands
  scq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_scan_byte (in_scan_byte),
    .in_from_aux  (in_from_aux),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // back: ring pointers, event memory, drop counter and output register
  scq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_valid (out_event_valid),
    .out_key_code    (out_key_code),
    .out_key_pressed (out_key_pressed),
    .out_drop_total  (out_drop_total)
  );

endmodule
